// ===== rtl/serial_packet_deframer_core_macros.svh =====
// ---------------------------------------------------------------------------
// serial_packet_deframer_core_macros.svh
// assertion macros used by the deframer checker
// ---------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_CORE_MACROS_SVH
`define SERIAL_PACKET_DEFRAMER_CORE_MACROS_SVH

// checked only outside reset
`define SPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");

// also checked while reset is applied
`define SPD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deframer reset assertion failed");

`endif

// ===== rtl/spd_pkg.sv =====
// ---------------------------------------------------------------------------
// spd_pkg
// types and constants of the serial packet deframer
// ---------------------------------------------------------------------------
package spd_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h41;
  localparam int         KIND_POS = 4;
  localparam logic [3:0] SEL_MASK = 4'hf;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] EV_INSTR = 2'd0;
  localparam logic [1:0] EV_TEXT  = 2'd1;
  localparam logic [1:0] EV_READ  = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ATTR = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [3:0] read_buffer;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] buffer_id;
    logic [7:0] payload_length;
    logic [7:0] read_data;
  } out_item_t;

  // store access of one beat
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } mem_ctl_t;

  // result descriptor produced by the framer, read data joins later
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [3:0] buf_id;
    logic [7:0] len;
    logic       rd_ok;
  } res_t;

endpackage

// ===== rtl/spd_framer.sv =====
// ---------------------------------------------------------------------------
// spd_framer
// header hunt state machine, packet bookkeeping and store access requests
// ---------------------------------------------------------------------------
module spd_framer import spd_pkg::*; #(
  parameter int NUM_BUFFERS  = 16,
  parameter int BUFFER_DEPTH = 256,
  parameter int ADDR_W       = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_item_t          in_item,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  output mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0] mem_addr,
  output res_t              res
);

  phase_t     phase_r, phase_nxt;
  logic       text_r, text_nxt;
  logic [3:0] tgt_r, tgt_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;
  logic [8:0] wcnt_r, wcnt_nxt;
  logic [8:0] bsize_r;
  logic [8:0] limit;
  logic [8:0] wcnt_inc;
  logic       rd_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      text_r    <= 1'b0;
      tgt_r     <= '0;
      exp_len_r <= '0;
      wcnt_r    <= '0;
      bsize_r   <= 9'd256;
    end else begin
      phase_r   <= phase_nxt;
      text_r    <= text_nxt;
      tgt_r     <= tgt_nxt;
      exp_len_r <= exp_len_nxt;
      wcnt_r    <= wcnt_nxt;
      if (cfg_we) begin
        bsize_r <= cfg_wdata;
      end
    end
  end

  assign limit    = (bsize_r < 9'(BUFFER_DEPTH)) ? bsize_r : 9'(BUFFER_DEPTH);
  assign wcnt_inc = wcnt_r + 9'd1;
  assign rd_ok    = ({1'b0, in_item.read_buffer} < 5'(NUM_BUFFERS)) &&
                    ({1'b0, in_item.read_index} < 9'(BUFFER_DEPTH));

  always_comb begin
    phase_nxt     = phase_r;
    text_nxt      = text_r;
    tgt_nxt       = tgt_r;
    exp_len_nxt   = exp_len_r;
    wcnt_nxt      = wcnt_r;
    mem_ctl.we    = 1'b0;
    mem_ctl.re    = 1'b0;
    mem_ctl.wdata = in_item.rx_byte;
    mem_addr      = ADDR_W'(tgt_r) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(wcnt_r);
    res.valid     = 1'b0;
    res.kind      = {1'b0, text_r};
    res.buf_id    = tgt_r;
    res.len       = exp_len_r;
    res.rd_ok     = 1'b0;
    if (accept) begin
      case (in_item.op)
        OP_TIMEOUT: begin
          phase_nxt = PH_HUNT;
        end
        OP_READ: begin
          mem_ctl.re = rd_ok;
          mem_addr   = ADDR_W'(in_item.read_buffer) * ADDR_W'(BUFFER_DEPTH) +
                       ADDR_W'(in_item.read_index);
          res.valid  = 1'b1;
          res.kind   = EV_READ;
          res.buf_id = in_item.read_buffer;
          res.len    = '0;
          res.rd_ok  = rd_ok;
        end
        OP_RX: begin
          case (phase_r)
            PH_HUNT: begin
              if (in_item.rx_byte == HDR_BYTE) begin
                phase_nxt = PH_ATTR;
              end
            end
            PH_ATTR: begin
              text_nxt  = in_item.rx_byte[KIND_POS];
              tgt_nxt   = in_item.rx_byte[3:0] & SEL_MASK;
              wcnt_nxt  = '0;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              exp_len_nxt = in_item.rx_byte;
              phase_nxt   = PH_DATA;
            end
            PH_DATA: begin
              mem_ctl.we = ({1'b0, tgt_r} < 5'(NUM_BUFFERS)) &&
                           (wcnt_r < 9'(BUFFER_DEPTH));
              wcnt_nxt   = wcnt_inc;
              // buffer limit wins over a matching length
              if (wcnt_inc >= limit) begin
                phase_nxt = PH_HUNT;
              end else if (wcnt_inc == {1'b0, exp_len_r}) begin
                phase_nxt = PH_HUNT;
                res.valid = 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_HUNT;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/spd_store.sv =====
// ---------------------------------------------------------------------------
// spd_store
// packet byte store, one access per cycle, registered read data
// ---------------------------------------------------------------------------
module spd_store import spd_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  mem_ctl_t          mem_ctl,
  input  logic [ADDR_W-1:0] mem_addr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[mem_addr] <= mem_ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/serial_packet_deframer_core.sv =====
// a result beat is registered in stage one (s1), then in the output register, before it shows on out_valid
// throughput: one input beat per cycle while in_stall is low; the store's single port serves
// the write or read, if any, that each beat needs at its accept edge
// a finished result waits in the output register while the next beat is taken
// reset: synchronous rst_n clears the framer state, buffer_size to 256 and the
// pipeline valids; store contents stay undefined, no clearing pass
// ---------------------------------------------------------------------------
// serial_packet_deframer_core
// serial packet deframer: framer, byte store and result pipeline
// ---------------------------------------------------------------------------
module serial_packet_deframer_core import spd_pkg::*; #(
  parameter int NUM_BUFFERS  = 16,
  parameter int BUFFER_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata
);

  localparam int DEPTH  = NUM_BUFFERS * BUFFER_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              accept;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  res_t              res;
  logic [7:0]        rdata;

  logic      s1_v_r, s1_v_nxt;
  res_t      s1_res_r;
  logic      out_v_r, out_v_nxt;
  out_item_t out_r;
  logic      s1_go;

  assign s1_go    = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign accept   = in_valid && !in_stall;

  spd_framer #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr),
    .res      (res)
  );

  spd_store #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .mem_addr(mem_addr),
    .rdata   (rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (res.valid) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = s1_go || (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // store read data lands alongside the descriptor in stage one
  always_ff @(posedge clk) begin
    if (res.valid) begin
      s1_res_r <= res;
    end
    if (s1_go) begin
      out_r.event_kind     <= s1_res_r.kind;
      out_r.buffer_id      <= s1_res_r.buf_id;
      out_r.payload_length <= s1_res_r.len;
      out_r.read_data      <= s1_res_r.rd_ok ? rdata : 8'd0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/spd_checker.sv =====
// ---------------------------------------------------------------------------
// spd_checker
// port level checks of the deframer, bound to the top level
// ---------------------------------------------------------------------------
`include "serial_packet_deframer_core_macros.svh"

module spd_checker import spd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `SPD_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid)
  `SPD_ASSERT(a_out_holds, out_valid && out_stall |=> out_valid && $stable(out_data))
  `SPD_ASSERT(a_stall_only_when_full, in_stall |-> out_valid && out_stall)
  `SPD_ASSERT(a_read_no_length, out_valid && out_data.event_kind == EV_READ |-> out_data.payload_length == 8'd0)
  `SPD_ASSERT(a_done_no_data, out_valid && out_data.event_kind != EV_READ |-> out_data.read_data == 8'd0)

endmodule

bind serial_packet_deframer_core spd_checker u_spd_checker (.*);
